### sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

### sv/iae_pkg.sv
`default_nettype none

package iae_pkg;

	localparam int IDX_W     = 7;
	localparam int ECNT_W    = 7;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int CAP_W     = 8;
	localparam int MODE_W    = 3;
	localparam int REP_W     = 2;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd1;
	localparam logic [CAP_W-1:0] CAP_MAX   = 8'd128;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_ERASE  = 3'd1,
		MODE_GET    = 3'd2,
		MODE_SET    = 3'd3,
		MODE_SIZE   = 3'd4,
		MODE_CAP    = 3'd5,
		MODE_PRINT  = 3'd6
	} mode_t;

	typedef enum logic [REP_W-1:0] {
		REP_ELEM  = 2'd0,
		REP_COUNT = 2'd1,
		REP_CAP   = 2'd2
	} report_t;

endpackage

`default_nettype wire

### sv/insertable_array_engine_top.sv
// Ordered array of signed 32-bit elements with insert, erase, get, set,
// size, capacity and print requests.
// Input channel s_axis: one word per request. tuser is the mode, tdata holds
// index, count and value, tlast ends an insert run.
// Output channel m_axis: one word per result. tuser is the report kind, tdata
// the reported value, tlast flags the final word of a request.
// The elements live in one single-port-read, single-port-write memory with a
// registered read. Insert and erase move the tail one element per cycle.
// Set writes on acceptance; size and capacity pass through the report state,
// get and print through the read stage, to the output register, print one word
// per cycle while m_axis_tready is high; insert moves the tail, then writes the
// value (at once when appending); erase moves the tail unless no element
// moves. A new request is taken once the move or read pipeline is empty; a
// result parked in the output register does not block it.
// Reset clears count, run offset and the output register and sets capacity
// to 1; memory contents are not cleared. When m_axis_tready is low the output
// register holds its word, a print pauses with one element parked in the read
// stage, and s_axis_tready drops until the stream drains.

`default_nettype none

`include "assert_macros.svh"

module insertable_array_engine_top #(
	parameter int DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [iae_pkg::S_DATA_W-1:0]     s_axis_tdata,  // index[6:0], count[13:7], value[45:14]
	input  wire  [iae_pkg::MODE_W-1:0]       s_axis_tuser,  // mode[2:0]
	input  wire                              s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [iae_pkg::M_DATA_W-1:0]     m_axis_tdata,  // result_value[31:0]
	output logic [iae_pkg::REP_W-1:0]        m_axis_tuser,  // report[1:0]
	output logic                             m_axis_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_MOVE,
		ST_INS_PUT,
		ST_ERS_MOVE,
		ST_RD_STREAM,
		ST_EMIT_REG
	} state_t;

	state_t                           state_q;
	logic [CW-1:0]                    cnt_q;
	logic [iae_pkg::CAP_W-1:0]        cap_q;
	logic [iae_pkg::ECNT_W-1:0]       run_off_q;
	logic [AW-1:0]                    ptr_q;
	logic [AW-1:0]                    end_q;
	logic [AW-1:0]                    dlt_q;
	logic [AW-1:0]                    pos_q;
	logic [iae_pkg::VAL_W-1:0]        val_q;
	iae_pkg::report_t                 rep_q;

	logic                             v_s1;
	logic                             wr_s1;
	logic [AW-1:0]                    addr_s1;
	logic                             last_s1;

	logic                             out_valid_q;
	iae_pkg::report_t                 out_rep_q;
	logic [iae_pkg::VAL_W-1:0]        out_val_q;
	logic                             out_last_q;

	logic [iae_pkg::VAL_W-1:0]        mem [DEPTH];
	logic [iae_pkg::VAL_W-1:0]        rd_data_q;

	logic                             accept;
	iae_pkg::mode_t                   in_mode;
	logic [iae_pkg::IDX_W-1:0]        in_idx;
	logic [iae_pkg::ECNT_W-1:0]       in_cnt;
	logic [iae_pkg::VAL_W-1:0]        in_val;
	logic [iae_pkg::POS_W-1:0]        pos_sum;
	logic [iae_pkg::POS_W-1:0]        n_ext;
	logic [iae_pkg::POS_W-1:0]        n_m1;
	logic [iae_pkg::POS_W-1:0]        idx_ext;
	logic [iae_pkg::POS_W-1:0]        avail;
	logic [iae_pkg::POS_W-1:0]        ers_k;
	logic [iae_pkg::POS_W-1:0]        ers_end;
	logic                             ins_ok;
	logic                             idx_ok;
	logic [CW-1:0]                    cnt_inc;

	logic                             out_free;
	logic                             em_load;
	logic                             s1_free;
	logic                             issue;
	logic [AW-1:0]                    issue_dst;
	logic                             issue_wr;
	logic                             issue_last;

	logic                             we;
	logic [AW-1:0]                    waddr;
	logic [iae_pkg::VAL_W-1:0]        wdata;

	assign s_axis_tready = (state_q == ST_IDLE) && !v_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign in_mode = iae_pkg::mode_t'(s_axis_tuser);
	assign in_idx  = s_axis_tdata[6:0];
	assign in_cnt  = s_axis_tdata[13:7];
	assign in_val  = s_axis_tdata[45:14];

	assign idx_ext = iae_pkg::POS_W'(in_idx);
	assign n_ext   = iae_pkg::POS_W'(cnt_q);
	assign n_m1    = n_ext - iae_pkg::POS_W'(1);
	assign pos_sum = idx_ext + iae_pkg::POS_W'(run_off_q);
	assign ins_ok  = (pos_sum <= n_ext) && (n_ext < iae_pkg::POS_W'(DEPTH));
	assign idx_ok  = idx_ext < n_ext;
	assign avail   = n_ext - idx_ext;
	assign ers_k   = (iae_pkg::POS_W'(in_cnt) > avail) ? avail : iae_pkg::POS_W'(in_cnt);
	assign ers_end = idx_ext + ers_k;
	assign cnt_inc = cnt_q + CW'(1);

	assign out_free = !out_valid_q || m_axis_tready;
	assign em_load  = v_s1 && !wr_s1 && out_free;
	assign s1_free  = !v_s1 || wr_s1 || em_load;

	always_comb begin
		issue      = 1'b0;
		issue_wr   = 1'b0;
		issue_dst  = ptr_q;
		issue_last = 1'b0;
		unique case (state_q)
			ST_INS_MOVE: begin
				issue     = 1'b1;
				issue_wr  = 1'b1;
				issue_dst = ptr_q + AW'(1);
			end
			ST_ERS_MOVE: begin
				issue     = 1'b1;
				issue_wr  = 1'b1;
				issue_dst = ptr_q - dlt_q;
			end
			ST_RD_STREAM: begin
				issue      = s1_free;
				issue_last = ptr_q == end_q;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rd_data_q;
		priority if (v_s1 && wr_s1) begin
			we = 1'b1;
		end else if (state_q == ST_INS_PUT) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = val_q;
		end else if (accept && in_mode == iae_pkg::MODE_SET && idx_ok) begin
			we    = 1'b1;
			waddr = in_idx[AW-1:0];
			wdata = in_val;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cap_q       <= iae_pkg::CAP_RESET;
			run_off_q   <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// read / move pipeline stage
			if (issue) begin
				v_s1    <= 1'b1;
				wr_s1   <= issue_wr;
				addr_s1 <= issue_dst;
				last_s1 <= issue_last;
			end else if (s1_free) begin
				v_s1 <= 1'b0;
			end

			// output register
			if (em_load) begin
				out_valid_q <= 1'b1;
				out_rep_q   <= iae_pkg::REP_ELEM;
				out_val_q   <= rd_data_q;
				out_last_q  <= last_s1;
			end else if (state_q == ST_EMIT_REG && out_free) begin
				out_valid_q <= 1'b1;
				out_rep_q   <= rep_q;
				out_val_q   <= (rep_q == iae_pkg::REP_COUNT) ?
					iae_pkg::VAL_W'(cnt_q) : iae_pkg::VAL_W'(cap_q);
				out_last_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_mode)
							iae_pkg::MODE_INSERT: begin
								if (ins_ok) begin
									pos_q <= pos_sum[AW-1:0];
									val_q <= in_val;
									ptr_q <= n_m1[AW-1:0];
									end_q <= pos_sum[AW-1:0];
									state_q <= (pos_sum == n_ext) ? ST_INS_PUT : ST_INS_MOVE;
								end
								if (s_axis_tlast) begin
									run_off_q <= '0;
								end else if (ins_ok) begin
									run_off_q <= run_off_q + iae_pkg::ECNT_W'(1);
								end
							end
							iae_pkg::MODE_ERASE: begin
								if (idx_ok && ers_k != '0) begin
									cnt_q <= cnt_q - CW'(ers_k);
									if (ers_end < n_ext) begin
										ptr_q   <= ers_end[AW-1:0];
										end_q   <= n_m1[AW-1:0];
										dlt_q   <= ers_k[AW-1:0];
										state_q <= ST_ERS_MOVE;
									end
								end
							end
							iae_pkg::MODE_GET: begin
								if (idx_ok) begin
									ptr_q   <= in_idx[AW-1:0];
									end_q   <= in_idx[AW-1:0];
									state_q <= ST_RD_STREAM;
								end
							end
							iae_pkg::MODE_PRINT: begin
								if (cnt_q != '0) begin
									ptr_q   <= '0;
									end_q   <= n_m1[AW-1:0];
									state_q <= ST_RD_STREAM;
								end
							end
							iae_pkg::MODE_SIZE: begin
								rep_q   <= iae_pkg::REP_COUNT;
								state_q <= ST_EMIT_REG;
							end
							iae_pkg::MODE_CAP: begin
								rep_q   <= iae_pkg::REP_CAP;
								state_q <= ST_EMIT_REG;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INS_MOVE: begin
					if (ptr_q == end_q) begin
						state_q <= ST_INS_PUT;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				ST_INS_PUT: begin
					if (!v_s1) begin
						cnt_q <= cnt_inc;
						if (cap_q <= iae_pkg::CAP_W'(cnt_inc) && cap_q < iae_pkg::CAP_MAX) begin
							cap_q <= cap_q << 1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ERS_MOVE: begin
					if (ptr_q == end_q) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_RD_STREAM: begin
					if (issue) begin
						if (issue_last) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				ST_EMIT_REG: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = out_rep_q;
	assign m_axis_tlast  = out_last_q;

	`ASSERT_IMPL(a_cap_above_count, 1'b1, cap_q > iae_pkg::CAP_W'(cnt_q))
	`ASSERT_IMPL(a_count_in_depth, 1'b1, iae_pkg::POS_W'(cnt_q) <= iae_pkg::POS_W'(DEPTH))
	`ASSERT_NEXT(a_parked_read_holds, v_s1 && !wr_s1 && !out_free, v_s1 && $stable(addr_s1) && $stable(rd_data_q))
	`ASSERT_IMPL(a_put_after_moves, state_q == ST_INS_PUT && !v_s1, !(accept))
	`ASSERT_IMPL(a_reg_report_is_last, out_valid_q && out_rep_q != iae_pkg::REP_ELEM, out_last_q)

endmodule

`default_nettype wire
